// File: design/osd_pkg.sv
`default_nettype none
package osd_pkg;

  localparam int unsigned SCREEN_ROWS = 22;
  localparam int unsigned SCREEN_COLS = 60;
  localparam int unsigned CELL_COUNT  = SCREEN_ROWS * SCREEN_COLS;
  localparam int unsigned ADDR_W      = $clog2(CELL_COUNT);
  localparam int unsigned ROW_W       = 5;
  localparam int unsigned COL_W       = 6;
  localparam int unsigned CODE_W      = 9;
  localparam int unsigned LEN_W       = 7;

  localparam logic [7:0] CMD_CLEAR     = 8'd2;
  localparam logic [7:0] CMD_WRITE_RUN = 8'd3;
  localparam logic [7:0] BLANK_RESET   = 8'd32;

  localparam logic [1:0] HDR_OPCODE = 2'd0;
  localparam logic [1:0] HDR_ROW    = 2'd1;
  localparam logic [1:0] HDR_COL    = 2'd2;
  localparam logic [1:0] HDR_LEN    = 2'd3;

  typedef struct packed {
    logic       dirty;
    logic       ext;
    logic [7:0] code;
  } cell_t;

  localparam int unsigned CELL_W = $bits(cell_t);

  typedef enum logic [1:0] {REQ_WRITE, REQ_READ, REQ_CLEAR, REQ_DRAW} req_e;
  typedef enum logic [2:0] {A_HOLD, A_ZERO, A_REQ, A_INC, A_ROW, A_START} addr_op_e;
  typedef enum logic [1:0] {W_BLANK, W_WRITE, W_CLEAN} wsel_e;
  typedef enum logic [2:0] {O_CLEAR, O_READ, O_CLEAN, O_HDR, O_CODE} out_sel_e;

  typedef enum logic [3:0] {
    ST_WIPE, ST_IDLE, ST_DECODE, ST_WR_RD, ST_WR_CMP, ST_RD_RD, ST_RD_OUT,
    ST_CLR_OUT, ST_D_ROW, ST_D_CLEAN, ST_D_RD, ST_D_CHK, ST_M_RD, ST_M_CHK,
    ST_HDR, ST_E_RD
  } state_e;

  typedef struct packed {
    logic     accept;
    addr_op_e addr_op;
    logic     ram_re;
    logic     ram_we;
    wsel_e    wsel;
    logic     flag_clr_all;
    logic     flag_set_req;
    logic     flag_clr_cur;
    logic     run_begin;
    logic     len_inc;
    logic     rem_load;
    logic     rem_dec;
    logic     hdr_zero;
    logic     hdr_inc;
    logic     out_load;
    out_sel_e out_sel;
  } cmd_t;

  typedef struct packed {
    req_e req;
    logic in_range;
    logic wr_diff;
    logic dirty;
    logic match;
    logic col_end;
    logic addr_end;
    logic any_flag;
    logic hdr_last;
    logic rem_one;
    logic out_room;
  } sts_t;

endpackage
`default_nettype wire

// File: design/osd_ram.sv
`default_nettype none
module osd_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic [$clog2(DEPTH)-1:0] addr_i,
  input  wire logic                     we_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[addr_i];
    end
  end

endmodule
`default_nettype wire

// File: design/osd_dp.sv
`default_nettype none
module osd_dp (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire osd_pkg::cmd_t              cmd_i,
  output osd_pkg::sts_t                   sts_o,
  input  wire logic [1:0]                 req_type_i,
  input  wire logic [osd_pkg::ROW_W-1:0]  row_i,
  input  wire logic [osd_pkg::COL_W-1:0]  col_i,
  input  wire logic [osd_pkg::CODE_W-1:0] char_i,
  input  wire logic                       cfg_we_i,
  input  wire logic [7:0]                 cfg_wdata_i,
  input  wire logic                       out_ready_i,
  output logic                            out_valid_o,
  output logic [7:0]                      out_byte_o,
  output logic                            byte_valid_o,
  output logic                            last_o,
  output logic [osd_pkg::CODE_W-1:0]      read_char_o,
  output logic                            read_ok_o,
  output logic                            clean_o
);

  localparam int unsigned AW = osd_pkg::ADDR_W;

  osd_pkg::req_e                     req_q;
  logic [osd_pkg::ROW_W-1:0]         rrow_q;
  logic [osd_pkg::COL_W-1:0]         rcol_q;
  logic [osd_pkg::CODE_W-1:0]        rchar_q;
  logic [AW-1:0]                     addr_q, addr_d;
  logic [osd_pkg::COL_W-1:0]         col_q, col_d;
  logic [osd_pkg::ROW_W-1:0]         crow_q, crow_d, frow;
  logic [osd_pkg::SCREEN_ROWS-1:0]   flags_q, flags_d;
  logic [AW-1:0]                     saddr_q;
  logic [osd_pkg::COL_W-1:0]         scol_q;
  logic                              sext_q;
  logic [osd_pkg::LEN_W-1:0]         len_q, len_d, rem_q, rem_d;
  logic [1:0]                        hdr_q, hdr_d;
  logic [7:0]                        blank_q;
  logic                              ovalid_q, ovalid_d;
  osd_pkg::cell_t                    rdata, wdata;
  logic [osd_pkg::CELL_W-1:0]        rword;
  logic [7:0]                        obyte_d, hbyte;
  logic                              obv_d, olast_d, ook_d, oclean_d;
  logic [osd_pkg::CODE_W-1:0]        ochar_d;

  assign rdata = osd_pkg::cell_t'(rword);

  osd_ram #(
    .WIDTH(osd_pkg::CELL_W),
    .DEPTH(osd_pkg::CELL_COUNT)
  ) u_ram (
    .clk_i  (clk_i),
    .addr_i (addr_q),
    .we_i   (cmd_i.ram_we),
    .wdata_i(wdata),
    .re_i   (cmd_i.ram_re),
    .rdata_o(rword)
  );

  always_comb begin
    frow = '0;
    for (int r = osd_pkg::SCREEN_ROWS - 1; r >= 0; r--) begin
      if (flags_q[r]) frow = osd_pkg::ROW_W'(r);
    end
  end

  always_comb begin
    addr_d = addr_q;
    col_d  = col_q;
    crow_d = crow_q;
    unique case (cmd_i.addr_op)
      osd_pkg::A_HOLD: ;
      osd_pkg::A_ZERO: addr_d = '0;
      osd_pkg::A_REQ: addr_d = AW'(rrow_q) * AW'(osd_pkg::SCREEN_COLS) + AW'(rcol_q);
      osd_pkg::A_INC: begin
        addr_d = addr_q + AW'(1);
        col_d  = col_q + osd_pkg::COL_W'(1);
      end
      osd_pkg::A_ROW: begin
        addr_d = AW'(frow) * AW'(osd_pkg::SCREEN_COLS);
        col_d  = '0;
        crow_d = frow;
      end
      osd_pkg::A_START: begin
        addr_d = saddr_q;
        col_d  = scol_q;
      end
      default: ;
    endcase
  end

  always_comb begin
    unique case (cmd_i.wsel)
      osd_pkg::W_BLANK: wdata = '{dirty: 1'b0, ext: 1'b0, code: blank_q};
      osd_pkg::W_WRITE: wdata = '{dirty: 1'b1, ext: rchar_q[8], code: rchar_q[7:0]};
      osd_pkg::W_CLEAN: wdata = '{dirty: 1'b0, ext: rdata.ext, code: rdata.code};
      default:          wdata = '{dirty: 1'b0, ext: 1'b0, code: blank_q};
    endcase
  end

  always_comb begin
    flags_d = flags_q;
    if (cmd_i.flag_clr_all) flags_d = '0;
    if (cmd_i.flag_set_req) flags_d[rrow_q] = 1'b1;
    if (cmd_i.flag_clr_cur) flags_d[crow_q] = 1'b0;
  end

  always_comb begin
    len_d = len_q;
    if (cmd_i.run_begin) len_d = osd_pkg::LEN_W'(1);
    else if (cmd_i.len_inc) len_d = len_q + osd_pkg::LEN_W'(1);
    rem_d = rem_q;
    if (cmd_i.rem_load) rem_d = len_q;
    else if (cmd_i.rem_dec) rem_d = rem_q - osd_pkg::LEN_W'(1);
    hdr_d = hdr_q;
    if (cmd_i.hdr_zero) hdr_d = osd_pkg::HDR_OPCODE;
    else if (cmd_i.hdr_inc) hdr_d = hdr_q + 2'd1;
  end

  always_comb begin
    unique case (hdr_q)
      osd_pkg::HDR_OPCODE: hbyte = osd_pkg::CMD_WRITE_RUN;
      osd_pkg::HDR_ROW:    hbyte = 8'(crow_q);
      osd_pkg::HDR_COL:    hbyte = 8'(scol_q);
      osd_pkg::HDR_LEN:    hbyte = {sext_q, len_q};
      default:             hbyte = osd_pkg::CMD_WRITE_RUN;
    endcase
  end

  always_comb begin
    obyte_d  = '0;
    obv_d    = 1'b0;
    olast_d  = 1'b0;
    ochar_d  = '0;
    ook_d    = 1'b0;
    oclean_d = 1'b0;
    unique case (cmd_i.out_sel)
      osd_pkg::O_CLEAR: begin
        obyte_d = osd_pkg::CMD_CLEAR;
        obv_d   = 1'b1;
        olast_d = 1'b1;
      end
      osd_pkg::O_READ: begin
        olast_d = 1'b1;
        ook_d   = sts_o.in_range;
        ochar_d = sts_o.in_range ? {rdata.ext, rdata.code} : '0;
      end
      osd_pkg::O_CLEAN: begin
        olast_d  = 1'b1;
        oclean_d = 1'b1;
      end
      osd_pkg::O_HDR: begin
        obyte_d = hbyte;
        obv_d   = 1'b1;
      end
      osd_pkg::O_CODE: begin
        obyte_d = rdata.code;
        obv_d   = 1'b1;
        olast_d = sts_o.rem_one;
      end
      default: ;
    endcase
  end

  always_comb begin
    ovalid_d = ovalid_q;
    if (cmd_i.out_load) ovalid_d = 1'b1;
    else if (out_ready_i) ovalid_d = 1'b0;
  end

  always_comb begin
    sts_o.req      = req_q;
    sts_o.in_range = (32'(rrow_q) < osd_pkg::SCREEN_ROWS) &&
                     (32'(rcol_q) < osd_pkg::SCREEN_COLS);
    sts_o.wr_diff  = (rdata.code != rchar_q[7:0]) || (rdata.ext != rchar_q[8]);
    sts_o.dirty    = rdata.dirty;
    sts_o.match    = rdata.dirty && (rdata.ext == sext_q);
    sts_o.col_end  = (col_q == osd_pkg::COL_W'(osd_pkg::SCREEN_COLS - 1));
    sts_o.addr_end = (addr_q == AW'(osd_pkg::CELL_COUNT - 1));
    sts_o.any_flag = |flags_q;
    sts_o.hdr_last = (hdr_q == osd_pkg::HDR_LEN);
    sts_o.rem_one  = (rem_q == osd_pkg::LEN_W'(1));
    sts_o.out_room = !ovalid_q || out_ready_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      addr_q   <= '0;
      col_q    <= '0;
      crow_q   <= '0;
      flags_q  <= '0;
      len_q    <= '0;
      rem_q    <= '0;
      hdr_q    <= osd_pkg::HDR_OPCODE;
      blank_q  <= osd_pkg::BLANK_RESET;
      ovalid_q <= 1'b0;
    end else begin
      addr_q   <= addr_d;
      col_q    <= col_d;
      crow_q   <= crow_d;
      flags_q  <= flags_d;
      len_q    <= len_d;
      rem_q    <= rem_d;
      hdr_q    <= hdr_d;
      ovalid_q <= ovalid_d;
      if (cfg_we_i) blank_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      req_q   <= osd_pkg::req_e'(req_type_i);
      rrow_q  <= row_i;
      rcol_q  <= col_i;
      rchar_q <= char_i;
    end
    if (cmd_i.run_begin) begin
      saddr_q <= addr_q;
      scol_q  <= col_q;
      sext_q  <= rdata.ext;
    end
    if (cmd_i.out_load) begin
      out_byte_o   <= obyte_d;
      byte_valid_o <= obv_d;
      last_o       <= olast_d;
      read_char_o  <= ochar_d;
      read_ok_o    <= ook_d;
      clean_o      <= oclean_d;
    end
  end

  assign out_valid_o = ovalid_q;

endmodule
`default_nettype wire

// File: design/osd_ctrl.sv
`default_nettype none
module osd_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_ready_o,
  input  wire osd_pkg::sts_t sts_i,
  output osd_pkg::cmd_t      cmd_o
);

  osd_pkg::state_e state_q, state_d;
  logic emit_q, emit_d;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      osd_pkg::ST_WIPE: if (sts_i.addr_end) state_d = osd_pkg::ST_IDLE;
      osd_pkg::ST_IDLE: if (in_valid_i) state_d = osd_pkg::ST_DECODE;
      osd_pkg::ST_DECODE: begin
        unique case (sts_i.req)
          osd_pkg::REQ_WRITE:
            state_d = sts_i.in_range ? osd_pkg::ST_WR_RD : osd_pkg::ST_IDLE;
          osd_pkg::REQ_READ:
            state_d = sts_i.in_range ? osd_pkg::ST_RD_RD : osd_pkg::ST_RD_OUT;
          osd_pkg::REQ_CLEAR: state_d = osd_pkg::ST_CLR_OUT;
          osd_pkg::REQ_DRAW:  state_d = osd_pkg::ST_D_ROW;
          default:            state_d = osd_pkg::ST_IDLE;
        endcase
      end
      osd_pkg::ST_WR_RD:  state_d = osd_pkg::ST_WR_CMP;
      osd_pkg::ST_WR_CMP: state_d = osd_pkg::ST_IDLE;
      osd_pkg::ST_RD_RD:  state_d = osd_pkg::ST_RD_OUT;
      osd_pkg::ST_RD_OUT: if (sts_i.out_room) state_d = osd_pkg::ST_IDLE;
      osd_pkg::ST_CLR_OUT: if (sts_i.out_room) state_d = osd_pkg::ST_WIPE;
      osd_pkg::ST_D_ROW:
        state_d = sts_i.any_flag ? osd_pkg::ST_D_RD : osd_pkg::ST_D_CLEAN;
      osd_pkg::ST_D_CLEAN: if (sts_i.out_room) state_d = osd_pkg::ST_IDLE;
      osd_pkg::ST_D_RD: state_d = osd_pkg::ST_D_CHK;
      osd_pkg::ST_D_CHK: begin
        if (sts_i.dirty) begin
          state_d = sts_i.col_end ? osd_pkg::ST_HDR : osd_pkg::ST_M_RD;
        end else begin
          state_d = sts_i.col_end ? osd_pkg::ST_D_ROW : osd_pkg::ST_D_RD;
        end
      end
      osd_pkg::ST_M_RD: state_d = osd_pkg::ST_M_CHK;
      osd_pkg::ST_M_CHK:
        state_d = (sts_i.match && !sts_i.col_end) ? osd_pkg::ST_M_RD : osd_pkg::ST_HDR;
      osd_pkg::ST_HDR: if (sts_i.out_room && sts_i.hdr_last) state_d = osd_pkg::ST_E_RD;
      osd_pkg::ST_E_RD:
        if (emit_q && sts_i.out_room && sts_i.rem_one) state_d = osd_pkg::ST_IDLE;
      default: state_d = osd_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o         = '0;
    cmd_o.addr_op = osd_pkg::A_HOLD;
    cmd_o.wsel    = osd_pkg::W_BLANK;
    cmd_o.out_sel = osd_pkg::O_CLEAR;
    in_ready_o    = 1'b0;
    emit_d        = emit_q;
    unique case (state_q)
      osd_pkg::ST_WIPE: begin
        cmd_o.ram_we  = 1'b1;
        cmd_o.addr_op = osd_pkg::A_INC;
      end
      osd_pkg::ST_IDLE: begin
        in_ready_o   = 1'b1;
        cmd_o.accept = in_valid_i;
      end
      osd_pkg::ST_DECODE: cmd_o.addr_op = osd_pkg::A_REQ;
      osd_pkg::ST_WR_RD, osd_pkg::ST_RD_RD, osd_pkg::ST_D_RD, osd_pkg::ST_M_RD:
        cmd_o.ram_re = 1'b1;
      osd_pkg::ST_WR_CMP: begin
        cmd_o.ram_we       = sts_i.wr_diff;
        cmd_o.wsel         = osd_pkg::W_WRITE;
        cmd_o.flag_set_req = sts_i.wr_diff;
      end
      osd_pkg::ST_RD_OUT: begin
        cmd_o.out_load = sts_i.out_room;
        cmd_o.out_sel  = osd_pkg::O_READ;
      end
      osd_pkg::ST_CLR_OUT: begin
        cmd_o.out_load     = sts_i.out_room;
        cmd_o.flag_clr_all = sts_i.out_room;
        if (sts_i.out_room) cmd_o.addr_op = osd_pkg::A_ZERO;
      end
      osd_pkg::ST_D_ROW: if (sts_i.any_flag) cmd_o.addr_op = osd_pkg::A_ROW;
      osd_pkg::ST_D_CLEAN: begin
        cmd_o.out_load = sts_i.out_room;
        cmd_o.out_sel  = osd_pkg::O_CLEAN;
      end
      osd_pkg::ST_D_CHK: begin
        cmd_o.run_begin    = sts_i.dirty;
        cmd_o.hdr_zero     = sts_i.dirty;
        cmd_o.flag_clr_cur = !sts_i.dirty && sts_i.col_end;
        if (!sts_i.col_end) cmd_o.addr_op = osd_pkg::A_INC;
      end
      osd_pkg::ST_M_CHK: begin
        cmd_o.len_inc  = sts_i.match;
        cmd_o.hdr_zero = !(sts_i.match && !sts_i.col_end);
        if (sts_i.match && !sts_i.col_end) cmd_o.addr_op = osd_pkg::A_INC;
      end
      osd_pkg::ST_HDR: begin
        cmd_o.out_load = sts_i.out_room;
        cmd_o.out_sel  = osd_pkg::O_HDR;
        cmd_o.hdr_inc  = sts_i.out_room;
        if (sts_i.out_room && sts_i.hdr_last) begin
          cmd_o.rem_load = 1'b1;
          cmd_o.addr_op  = osd_pkg::A_START;
          emit_d         = 1'b0;
        end
      end
      osd_pkg::ST_E_RD: begin
        if (!emit_q) begin
          cmd_o.ram_re = 1'b1;
          emit_d       = 1'b1;
        end else if (sts_i.out_room) begin
          cmd_o.out_load = 1'b1;
          cmd_o.out_sel  = osd_pkg::O_CODE;
          cmd_o.ram_we   = 1'b1;
          cmd_o.wsel     = osd_pkg::W_CLEAN;
          cmd_o.rem_dec  = 1'b1;
          emit_d         = 1'b0;
          if (!sts_i.rem_one) cmd_o.addr_op = osd_pkg::A_INC;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= osd_pkg::ST_WIPE;
      emit_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      emit_q  <= emit_d;
    end
  end

  a_load_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_load |-> sts_i.out_room) else $error("result register overwritten");
  a_ram_port: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd_o.ram_re && cmd_o.ram_we)) else $error("ram read and write together");
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.accept |=> state_q == osd_pkg::ST_DECODE) else $error("beat not taken up");
  a_emit_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.rem_dec |-> cmd_o.out_sel == osd_pkg::O_CODE) else $error("stray run byte");

endmodule
`default_nettype wire

// File: design/osd_shadow_screen_dirty_run_encoder.sv
// Shadow OSD character screen (22 rows of 60 cells) with a dirty-run encoder.
// One item at a time: s_axis_tready is high only while the block is idle.
// After reset, and after every clear request, a clearing pass writes the blank
// code into the cell memory before the next beat is taken.
// A write on the screen reads the cell and rewrites it only if the code differs,
// and off the screen it is dropped; a read waits for room at the output.
// A draw-next scans the cell memory cell by cell, reading and then checking each,
// starting at the first row marked as touched; it then reads on to measure the
// run, sends 4 header bytes, and sends the run bytes, each read from the
// single-port cell memory and written back clean.
`default_nettype none
module osd_shadow_screen_dirty_run_encoder (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [23:0] s_axis_tdata,  // row[4:0], col[10:5], char_code[19:11]
  input  wire logic [1:0]  s_axis_tuser,  // req_type[1:0]
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [23:0]      m_axis_tdata,  // out_byte[7:0], read_char[16:8]
  output logic [2:0]       m_axis_tuser,  // byte_valid[0], read_ok[1], screen_clean[2]
  output logic             m_axis_tlast,
  input  wire logic        cfg_we_i,
  input  wire logic [7:0]  cfg_wdata_i
);

  osd_pkg::cmd_t                cmd;
  osd_pkg::sts_t                sts;
  logic [7:0]                   out_byte;
  logic                         byte_valid, read_ok, clean;
  logic [osd_pkg::CODE_W-1:0]   read_char;

  osd_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(s_axis_tvalid),
    .in_ready_o(s_axis_tready),
    .sts_i     (sts),
    .cmd_o     (cmd)
  );

  osd_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .req_type_i  (s_axis_tuser),
    .row_i       (s_axis_tdata[4:0]),
    .col_i       (s_axis_tdata[10:5]),
    .char_i      (s_axis_tdata[19:11]),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .out_ready_i (m_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_byte_o  (out_byte),
    .byte_valid_o(byte_valid),
    .last_o      (m_axis_tlast),
    .read_char_o (read_char),
    .read_ok_o   (read_ok),
    .clean_o     (clean)
  );

  assign m_axis_tdata = {7'd0, read_char, out_byte};
  assign m_axis_tuser = {clean, read_ok, byte_valid};

endmodule
`default_nettype wire

// File: test/tb_top.sv
`default_nettype none
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       last;
    logic [8:0] read_char;
    logic       read_ok;
    logic       clean;
  } beat_t;

  typedef struct packed {
    osd_pkg::req_e req;
    logic [4:0]    row;
    logic [5:0]    col;
    logic [8:0]    code;
    logic          typed;
    beat_t         exp_beat;
  } row_t;

  localparam beat_t NO_BEAT = '0;
  localparam int unsigned WATCHDOG_LIMIT = 12000;

  logic clk_i, rst_ni;
  logic s_axis_tvalid, s_axis_tready;
  logic [23:0] s_axis_tdata;
  logic [1:0] s_axis_tuser;
  logic m_axis_tvalid, m_axis_tready;
  logic [23:0] m_axis_tdata;
  logic [2:0] m_axis_tuser;
  logic m_axis_tlast;
  logic cfg_we_i;
  logic [7:0] cfg_wdata_i;

  osd_shadow_screen_dirty_run_encoder u_top (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
    .m_axis_tlast(m_axis_tlast),
    .cfg_we_i(cfg_we_i), .cfg_wdata_i(cfg_wdata_i)
  );

  logic [7:0] shadow_code [osd_pkg::CELL_COUNT];
  logic       shadow_ext [osd_pkg::CELL_COUNT];
  logic       shadow_dirty [osd_pkg::CELL_COUNT];
  logic [7:0] shadow_blank;
  beat_t      pending_beats[$];
  int         errors;
  bit         idle_on;
  bit         long_hold_req;
  int         items_sent;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  task automatic report(string what, int unsigned exp_v, int unsigned got_v);
    $display("mismatch %s: expected %0d got %0d at %0t", what, exp_v, got_v, $realtime);
    errors++;
  endtask

  function automatic void push_beat(logic [7:0] b, logic bv, logic lst, logic [8:0] rc,
                                    logic rok, logic cln);
    beat_t e;
    e.out_byte = b;
    e.byte_valid = bv;
    e.last = lst;
    e.read_char = rc;
    e.read_ok = rok;
    e.clean = cln;
    pending_beats.push_back(e);
  endfunction

  function automatic void wipe_shadow();
    for (int i = 0; i < osd_pkg::CELL_COUNT; i++) begin
      shadow_code[i] = shadow_blank;
      shadow_ext[i] = 1'b0;
      shadow_dirty[i] = 1'b0;
    end
  endfunction

  function automatic void predict_screen(osd_pkg::req_e req, logic [4:0] row,
                                         logic [5:0] col, logic [8:0] code);
    int idx, first, r, c, stop;
    logic on_screen, ext;
    on_screen = (row < osd_pkg::SCREEN_ROWS) && (col < osd_pkg::SCREEN_COLS);
    idx = int'(row) * osd_pkg::SCREEN_COLS + int'(col);
    case (req)
      osd_pkg::REQ_WRITE: begin
        if (on_screen && (shadow_code[idx] != code[7:0] || shadow_ext[idx] != code[8])) begin
          shadow_code[idx] = code[7:0];
          shadow_ext[idx] = code[8];
          shadow_dirty[idx] = 1'b1;
        end
      end
      osd_pkg::REQ_READ: begin
        if (on_screen) push_beat(8'd0, 1'b0, 1'b1, {shadow_ext[idx], shadow_code[idx]}, 1'b1, 1'b0);
        else push_beat(8'd0, 1'b0, 1'b1, 9'd0, 1'b0, 1'b0);
      end
      osd_pkg::REQ_CLEAR: begin
        wipe_shadow();
        push_beat(osd_pkg::CMD_CLEAR, 1'b1, 1'b1, 9'd0, 1'b0, 1'b0);
      end
      default: begin
        first = -1;
        for (int i = 0; i < osd_pkg::CELL_COUNT; i++) begin
          if (first < 0 && shadow_dirty[i]) first = i;
        end
        if (first < 0) begin
          push_beat(8'd0, 1'b0, 1'b1, 9'd0, 1'b0, 1'b1);
        end else begin
          r = first / osd_pkg::SCREEN_COLS;
          c = first % osd_pkg::SCREEN_COLS;
          ext = shadow_ext[first];
          stop = first + 1;
          while (c + (stop - first) < osd_pkg::SCREEN_COLS && shadow_dirty[stop] &&
                 shadow_ext[stop] == ext)
            stop++;
          push_beat(osd_pkg::CMD_WRITE_RUN, 1'b1, 1'b0, 9'd0, 1'b0, 1'b0);
          push_beat(8'(r), 1'b1, 1'b0, 9'd0, 1'b0, 1'b0);
          push_beat(8'(c), 1'b1, 1'b0, 9'd0, 1'b0, 1'b0);
          push_beat({ext, 7'(stop - first)}, 1'b1, 1'b0, 9'd0, 1'b0, 1'b0);
          for (int k = first; k < stop; k++) begin
            shadow_dirty[k] = 1'b0;
            push_beat(shadow_code[k], 1'b1, (k + 1 == stop), 9'd0, 1'b0, 1'b0);
          end
        end
      end
    endcase
  endfunction

  task automatic send_item(osd_pkg::req_e req, logic [4:0] row, logic [5:0] col,
                           logic [8:0] code, bit typed, beat_t typed_beat);
    int gap;
    gap = idle_on ? $urandom_range(0, 8) : 0;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= req;
    s_axis_tdata <= {4'd0, code, col, row};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    predict_screen(req, row, col, code);
    if (typed) pending_beats[$] = typed_beat;
    items_sent++;
  endtask

  task automatic send_plain(osd_pkg::req_e req, logic [4:0] row, logic [5:0] col,
                            logic [8:0] code);
    send_item(req, row, col, code, 1'b0, NO_BEAT);
  endtask

  task automatic drain_and_configure(logic [7:0] blank);
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending_beats.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= blank;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    shadow_blank = blank;
  endtask

  task automatic random_phase(int count);
    int n, kind, len;
    logic [4:0] r;
    logic [5:0] c;
    logic [8:0] code;
    n = 0;
    while (n < count) begin
      kind = $urandom_range(0, 99);
      if (kind < 40) begin
        r = 5'($urandom_range(0, osd_pkg::SCREEN_ROWS - 1));
        c = 6'($urandom_range(0, osd_pkg::SCREEN_COLS - 1));
        len = $urandom_range(1, 10);
        code[8] = 1'($urandom_range(0, 1));
        for (int k = 0; k < len && n < count; k++) begin
          code[7:0] = 8'($urandom);
          if ($urandom_range(0, 9) == 0) code[8] = ~code[8];
          send_plain(osd_pkg::REQ_WRITE, r, 6'((int'(c) + k) % 64), code);
          n++;
        end
        if ($urandom_range(0, 2) != 0 && n < count) begin
          send_plain(osd_pkg::REQ_DRAW, 5'd0, 6'd0, 9'd0);
          n++;
        end
      end else begin
        r = ($urandom_range(0, 9) == 0) ? 5'($urandom_range(0, 31))
                                        : 5'($urandom_range(0, osd_pkg::SCREEN_ROWS - 1));
        c = ($urandom_range(0, 9) == 0) ? 6'($urandom_range(0, 63))
                                        : 6'($urandom_range(0, osd_pkg::SCREEN_COLS - 1));
        code = ($urandom_range(0, 4) == 0) ? {1'b0, shadow_blank} : 9'($urandom);
        if (kind < 60) send_plain(osd_pkg::REQ_WRITE, r, c, code);
        else if (kind < 78) send_plain(osd_pkg::REQ_READ, r, c, code);
        else if (kind < 97) send_plain(osd_pkg::REQ_DRAW, r, c, code);
        else send_plain(osd_pkg::REQ_CLEAR, r, c, code);
        n++;
      end
    end
  endtask

  row_t directed [20];

  initial begin
    rst_ni = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = '0;
    cfg_we_i = 1'b0;
    cfg_wdata_i = '0;
    errors = 0;
    items_sent = 0;
    idle_on = 1'b1;
    long_hold_req = 1'b0;
    shadow_blank = osd_pkg::BLANK_RESET;
    wipe_shadow();
    directed = '{
      '{osd_pkg::REQ_READ,  5'd0,  6'd0,  9'h000, 1'b1,
        '{8'd0, 1'b0, 1'b1, 9'd32, 1'b1, 1'b0}},
      '{osd_pkg::REQ_READ,  5'd31, 6'd63, 9'h1FF, 1'b1,
        '{8'd0, 1'b0, 1'b1, 9'd0, 1'b0, 1'b0}},
      '{osd_pkg::REQ_READ,  5'd21, 6'd60, 9'h000, 1'b1,
        '{8'd0, 1'b0, 1'b1, 9'd0, 1'b0, 1'b0}},
      '{osd_pkg::REQ_READ,  5'd22, 6'd0,  9'h000, 1'b1,
        '{8'd0, 1'b0, 1'b1, 9'd0, 1'b0, 1'b0}},
      '{osd_pkg::REQ_DRAW,  5'd0,  6'd0,  9'h000, 1'b1,
        '{8'd0, 1'b0, 1'b1, 9'd0, 1'b0, 1'b1}},
      '{osd_pkg::REQ_WRITE, 5'd1,  6'd0,  9'd32,  1'b0, NO_BEAT},
      '{osd_pkg::REQ_WRITE, 5'd22, 6'd5,  9'h0AA, 1'b0, NO_BEAT},
      '{osd_pkg::REQ_WRITE, 5'd5,  6'd60, 9'h055, 1'b0, NO_BEAT},
      '{osd_pkg::REQ_DRAW,  5'd0,  6'd0,  9'h000, 1'b1,
        '{8'd0, 1'b0, 1'b1, 9'd0, 1'b0, 1'b1}},
      '{osd_pkg::REQ_WRITE, 5'd0,  6'd0,  9'h1FF, 1'b0, NO_BEAT},
      '{osd_pkg::REQ_WRITE, 5'd0,  6'd1,  9'h141, 1'b0, NO_BEAT},
      '{osd_pkg::REQ_WRITE, 5'd0,  6'd2,  9'h041, 1'b0, NO_BEAT},
      '{osd_pkg::REQ_WRITE, 5'd2,  6'd58, 9'h0FF, 1'b0, NO_BEAT},
      '{osd_pkg::REQ_WRITE, 5'd2,  6'd59, 9'h000, 1'b0, NO_BEAT},
      '{osd_pkg::REQ_WRITE, 5'd3,  6'd0,  9'h07E, 1'b0, NO_BEAT},
      '{osd_pkg::REQ_WRITE, 5'd21, 6'd59, 9'h100, 1'b0, NO_BEAT},
      '{osd_pkg::REQ_READ,  5'd0,  6'd1,  9'h000, 1'b0, NO_BEAT},
      '{osd_pkg::REQ_DRAW,  5'd0,  6'd0,  9'h000, 1'b0, NO_BEAT},
      '{osd_pkg::REQ_CLEAR, 5'd0,  6'd0,  9'h000, 1'b1,
        '{osd_pkg::CMD_CLEAR, 1'b1, 1'b1, 9'd0, 1'b0, 1'b0}},
      '{osd_pkg::REQ_DRAW,  5'd0,  6'd0,  9'h000, 1'b1,
        '{8'd0, 1'b0, 1'b1, 9'd0, 1'b0, 1'b1}}
    };
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    for (int i = 0; i < 20; i++) begin
      send_item(directed[i].req, directed[i].row, directed[i].col, directed[i].code,
                directed[i].typed, directed[i].exp_beat);
      if (i == 16) for (int k = 0; k < 4; k++) send_plain(osd_pkg::REQ_DRAW, 5'd0, 6'd0, 9'd0);
    end
    drain_and_configure(8'd0);
    send_plain(osd_pkg::REQ_CLEAR, 5'd0, 6'd0, 9'd0);
    long_hold_req = 1'b1;
    random_phase(75);
    drain_and_configure(8'd255);
    send_plain(osd_pkg::REQ_CLEAR, 5'd0, 6'd0, 9'd0);
    idle_on = 1'b0;
    random_phase(75);
    idle_on = 1'b1;
    drain_and_configure(8'($urandom));
    send_plain(osd_pkg::REQ_CLEAR, 5'd0, 6'd0, 9'd0);
    random_phase(75);
    drain_and_configure(osd_pkg::BLANK_RESET);
    send_plain(osd_pkg::REQ_CLEAR, 5'd0, 6'd0, 9'd0);
    random_phase(70);
    for (int k = 0; k < 12; k++) send_plain(osd_pkg::REQ_DRAW, 5'd0, 6'd0, 9'd0);
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending_beats.size() != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    int hold, n;
    hold = 0;
    m_axis_tready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold > 0) begin
        hold--;
        if (hold == 0) m_axis_tready <= 1'b1;
      end else if (long_hold_req) begin
        long_hold_req = 1'b0;
        hold = 400;
        m_axis_tready <= 1'b0;
      end else if (m_axis_tvalid && m_axis_tready) begin
        n = idle_on ? $urandom_range(0, 8) : 0;
        if (n > 0) begin
          hold = n;
          m_axis_tready <= 1'b0;
        end
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    beat_t e;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_beats.size() == 0) begin
        report("unexpected beat, out_byte", 0, m_axis_tdata[7:0]);
      end else begin
        e = pending_beats.pop_front();
        if (m_axis_tdata[7:0] != e.out_byte) report("out_byte", e.out_byte, m_axis_tdata[7:0]);
        if (m_axis_tdata[16:8] != e.read_char)
          report("read_char", e.read_char, m_axis_tdata[16:8]);
        if (m_axis_tuser[0] != e.byte_valid) report("byte_valid", e.byte_valid, m_axis_tuser[0]);
        if (m_axis_tuser[1] != e.read_ok) report("read_ok", e.read_ok, m_axis_tuser[1]);
        if (m_axis_tuser[2] != e.clean) report("screen_clean", e.clean, m_axis_tuser[2]);
        if (m_axis_tlast != e.last) report("last", e.last, m_axis_tlast);
      end
    end
  end

  always @(posedge clk_i) begin
    int unsigned quiet;
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet = 0;
    end else begin
      quiet++;
      if (quiet == WATCHDOG_LIMIT) begin
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

endmodule
`default_nettype wire
